// ----- sv/ebmlh_pkg.sv -----
package ebmlh_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VAL_W   = 56;
    localparam int unsigned TOTAL_W = 57;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned REM_W   = 3;
    localparam int unsigned LZ_W    = 4;
    localparam int unsigned STAT_W  = 2;

    localparam logic [BYTE_W-1:0] FIRST_MASK = 8'h7f;
    localparam logic [VAL_W-1:0]  RESERVED_VAL = 56'h7f;

    typedef enum logic [1:0] {
        PH_ID_FIRST  = 2'd0,
        PH_ID_TAIL   = 2'd1,
        PH_LEN_FIRST = 2'd2,
        PH_LEN_TAIL  = 2'd3
    } phase_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_ID_FAIL  = 2'd1,
        ST_LEN_FAIL = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0]   element_id;
        logic [VAL_W-1:0]   data_length;
        logic [COUNT_W-1:0] header_bytes;
        logic [TOTAL_W-1:0] total_bytes;
        status_t            status;
    } result_t;

    // Leading zero count of one byte; 8 for zero.
    function automatic logic [LZ_W-1:0] lead_zeros(input logic [BYTE_W-1:0] b);
        logic [LZ_W-1:0] n;
        logic            found;
        n     = LZ_W'(BYTE_W);
        found = 1'b0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (!found && b[i]) begin
                n     = LZ_W'(BYTE_W - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ----- sv/ebmlh_if.sv -----
interface ebmlh_in_if
    import ebmlh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_available;

    modport source (output valid, output data_byte, output last_available, input ready);
    modport sink   (input valid, input data_byte, input last_available, output ready);
endinterface

interface ebmlh_out_if
    import ebmlh_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VAL_W-1:0]   element_id;
    logic [VAL_W-1:0]   data_length;
    logic [COUNT_W-1:0] header_bytes;
    logic [TOTAL_W-1:0] total_bytes;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output element_id, output data_length,
                    output header_bytes, output total_bytes, output status, input ready);
    modport sink   (input valid, input element_id, input data_length,
                    input header_bytes, input total_bytes, input status, output ready);
endinterface

// ----- sv/ebmlh_step.sv -----
module ebmlh_step
    import ebmlh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_available,
    output logic              res_valid,
    output result_t           res
);

    phase_t             phase_reg, phase_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic [VAL_W-1:0]   id_reg, id_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               is_len;
    logic               first;
    logic [LZ_W-1:0]    nz;
    logic               zero_first;
    logic [VAL_W-1:0]   acc_new;
    logic [REM_W-1:0]   rem_new;
    logic               done;
    logic               one_byte;
    logic               reserved;
    logic [COUNT_W-1:0] count_inc;
    logic               emit;
    status_t            emit_status;
    logic [VAL_W-1:0]   emit_id;

    // Decode the current byte against the held state.
    always_comb
    begin
        is_len     = phase_reg[1];
        first      = !phase_reg[0];
        nz         = lead_zeros(data_byte);
        zero_first = first && nz[LZ_W-1];
        count_inc  = count_reg + COUNT_W'(1);
        if (first)
        begin
            acc_new  = VAL_W'(data_byte & (FIRST_MASK >> nz));
            rem_new  = nz[REM_W-1:0];
            done     = (nz == '0);
            one_byte = (nz == '0);
        end
        else
        begin
            acc_new  = {acc_reg[VAL_W-BYTE_W-1:0], data_byte};
            rem_new  = rem_reg - REM_W'(1);
            done     = (rem_new == '0);
            one_byte = 1'b0;
        end
        reserved = one_byte && (acc_new == RESERVED_VAL);

        emit        = 1'b0;
        emit_status = ST_OK;
        emit_id     = id_reg;
        if (zero_first)
        begin
            emit        = 1'b1;
            emit_status = is_len ? ST_LEN_FAIL : ST_ID_FAIL;
            emit_id     = is_len ? id_reg : '0;
        end
        else if (!is_len)
        begin
            if (done && reserved)
            begin
                emit        = 1'b1;
                emit_status = ST_ID_FAIL;
                emit_id     = '0;
            end
            else if (done && last_available)
            begin
                emit        = 1'b1;
                emit_status = ST_LEN_FAIL;
                emit_id     = acc_new;
            end
            else if (!done && last_available)
            begin
                emit        = 1'b1;
                emit_status = ST_ID_FAIL;
                emit_id     = '0;
            end
        end
        else
        begin
            if (done)
            begin
                emit        = 1'b1;
                emit_status = reserved ? ST_UNKNOWN : ST_OK;
            end
            else if (last_available)
            begin
                emit        = 1'b1;
                emit_status = ST_LEN_FAIL;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        id_next    = id_reg;
        count_next = count_reg;
        if (adv)
        begin
            if (emit)
            begin
                phase_next = PH_ID_FIRST;
                rem_next   = '0;
                acc_next   = '0;
                id_next    = '0;
                count_next = '0;
            end
            else if (!is_len && done)
            begin
                phase_next = PH_LEN_FIRST;
                rem_next   = rem_new;
                acc_next   = '0;
                id_next    = acc_new;
                count_next = count_inc;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ID_FIRST:  phase_next = PH_ID_TAIL;
                    PH_LEN_FIRST: phase_next = PH_LEN_TAIL;
                    default:      phase_next = phase_reg;
                endcase
                rem_next   = rem_new;
                acc_next   = acc_new;
                count_next = count_inc;
            end
        end
    end

    always_comb
    begin
        res_valid        = adv && emit;
        res.element_id   = emit_id;
        res.header_bytes = count_inc;
        res.status       = emit_status;
        if (emit_status == ST_OK)
        begin
            res.data_length = acc_new;
            res.total_bytes = {1'b0, acc_new} + TOTAL_W'(count_inc);
        end
        else
        begin
            res.data_length = '0;
            res.total_bytes = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID_FIRST;
            rem_reg   <= '0;
            acc_reg   <= '0;
            id_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            id_reg    <= id_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/ebmlh_out_reg.sv -----
module ebmlh_out_reg
    import ebmlh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    free,
    ebmlh_out_if.source out_ch
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Slot frees when empty or when its word is taken this cycle.
    assign free = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.element_id   = res_reg.element_id;
    assign out_ch.data_length  = res_reg.data_length;
    assign out_ch.header_bytes = res_reg.header_bytes;
    assign out_ch.total_bytes  = res_reg.total_bytes;
    assign out_ch.status       = res_reg.status;

endmodule

// ----- sv/ebml_element_header_decoder_core.sv -----
// EBML element header decoder: one header byte per word, ID then data length.
// The last header byte is registered, decoded, and its result word registered for output.
// Throughput: one byte per cycle while the result side keeps up; the single
// result register stalls input only when a result is waiting and not taken.
// Reset (rst_n, async, active low) clears the decode state and both valids.
module ebml_element_header_decoder_core
    import ebmlh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ebmlh_in_if.sink    in_ch,
    ebmlh_out_if.source out_ch
);

    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              out_free;
    logic              adv;
    logic              in_take;
    logic              res_valid;
    result_t           res;

    assign adv         = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_ch.data_byte;
            s1_last_reg <= in_ch.last_available;
        end
    end

    ebmlh_step u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .data_byte      (s1_byte_reg),
        .last_available (s1_last_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    ebmlh_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_valid),
        .res    (res),
        .free   (out_free),
        .out_ch (out_ch)
    );

endmodule

// ----- sv/ebmlh_checker.sv -----
module ebmlh_checker
    import ebmlh_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [VAL_W-1:0]   element_id,
    input logic [VAL_W-1:0]   data_length,
    input logic [COUNT_W-1:0] header_bytes,
    input logic [TOTAL_W-1:0] total_bytes,
    input logic [STAT_W-1:0]  status
);

    // Hold the total and status of a stalled result word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(total_bytes) && $stable(status))
        else $error("stalled result changed");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |->
            total_bytes == ({1'b0, data_length} + TOTAL_W'(header_bytes)))
        else $error("total_bytes mismatch");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> data_length == '0 && total_bytes == '0)
        else $error("length not zeroed on failure");

    a_id_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ID_FAIL |-> element_id == '0)
        else $error("ID not zeroed on ID failure");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> header_bytes != '0 && header_bytes <= COUNT_W'(16))
        else $error("header_bytes out of range");

endmodule

bind ebml_element_header_decoder_core ebmlh_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .element_id   (out_ch.element_id),
    .data_length  (out_ch.data_length),
    .header_bytes (out_ch.header_bytes),
    .total_bytes  (out_ch.total_bytes),
    .status       (out_ch.status)
);
